>>> rtl/hol_pkg.sv
`default_nettype none

package hol_pkg;

    // result kinds on the output channel
    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    // characters of the column layout
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PIPE  = 8'h7C;

    // fixed columns
    localparam logic [4:0] COL_ADDR_FIRST = 5'd2;
    localparam logic [4:0] COL_ADDR_LAST  = 5'd4;
    localparam logic [4:0] COL_COLON      = 5'd5;
    localparam logic [4:0] COL_SPACE      = 5'd6;
    localparam logic [4:0] COL_DATA       = 5'd7;
    localparam logic [4:0] COL_PIPE       = 5'd28;
    localparam logic [4:0] LINE_COLS      = 5'd29;

    // line summary handed from the parser to the line-end logic
    typedef struct packed {
        logic        full_len;
        logic        pipe_ok;
        logic        all_blank;
        logic        header_bad;
        logic        data_bad;
        logic        digit_odd;
        logic        space_six_ok;
        logic [3:0]  bytes;
        logic [11:0] address;
    } line_stat_t;

    // hex digit decode: bit 4 set when the character is a hex digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/hol_if.sv
`default_nettype none

// input channel: one character or a line end per transaction
interface hol_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       line_end;

    modport source (output valid, output char_code, output line_end, input ready);
    modport sink (input valid, input char_code, input line_end, output ready);
endinterface

// output channel: one memory write or status per transaction
interface hol_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [11:0] write_address;
    logic [7:0]  write_data;
    logic        last_of_run;

    modport source (output valid, output result_kind, output write_address,
                    output write_data, output last_of_run, input ready);
    modport sink (input valid, input result_kind, input write_address,
                  input write_data, input last_of_run, output ready);
endinterface

`default_nettype wire

>>> rtl/hol_ram.sv
`default_nettype none

module hol_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 10,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AddrW-1:0] wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AddrW-1:0] rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/hol_parse.sv
`default_nettype none

module hol_parse #(
    parameter int MAX_LINE_BYTES = 10,
    localparam int BufAw = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             char_take,
    input  wire logic [7:0]       char_code,
    input  wire logic             line_clear,
    output hol_pkg::line_stat_t   stat,
    output logic                  buf_wr_en,
    output logic      [BufAw-1:0] buf_wr_addr,
    output logic      [7:0]       buf_wr_data
);

    import hol_pkg::*;

    logic [4:0]  column_reg, column_next;
    logic [11:0] addr_reg, addr_next;
    logic [4:0]  digits_reg, digits_next;
    logic        ended_reg, ended_next;
    logic        blank_reg, blank_next;
    logic        hbad_reg, hbad_next;
    logic        dbad_reg, dbad_next;
    logic        pipe_reg, pipe_next;
    logic        six_reg, six_next;
    logic [3:0]  hi_reg, hi_next;
    logic [4:0]  hex;
    logic [3:0]  byte_idx;

    assign hex      = hex_decode(char_code);
    assign byte_idx = digits_reg[4:1];

    // column checks for one character; a line end clears the line state
    always_comb
    begin
        column_next = column_reg;
        addr_next   = addr_reg;
        digits_next = digits_reg;
        ended_next  = ended_reg;
        blank_next  = blank_reg;
        hbad_next   = hbad_reg;
        dbad_next   = dbad_reg;
        pipe_next   = pipe_reg;
        six_next    = six_reg;
        hi_next     = hi_reg;
        buf_wr_en   = 1'b0;
        buf_wr_addr = byte_idx[BufAw-1:0];
        buf_wr_data = {hi_reg, hex[3:0]};
        if (line_clear)
        begin
            column_next = 5'd0;
            addr_next   = 12'd0;
            digits_next = 5'd0;
            ended_next  = 1'b0;
            blank_next  = 1'b1;
            hbad_next   = 1'b0;
            dbad_next   = 1'b0;
            pipe_next   = 1'b0;
            six_next    = 1'b0;
        end
        else if (char_take && column_reg < LINE_COLS)
        begin
            column_next = column_reg + 5'd1;
            if (column_reg >= COL_ADDR_FIRST && column_reg < COL_PIPE &&
                char_code != CH_SPACE)
            begin
                blank_next = 1'b0;
            end
            if (column_reg == 5'd0)
            begin
                if (char_code != CH_ZERO) hbad_next = 1'b1;
            end
            else if (column_reg == 5'd1)
            begin
                if (char_code != CH_X) hbad_next = 1'b1;
            end
            else if (column_reg <= COL_ADDR_LAST)
            begin
                if (!hex[4]) hbad_next = 1'b1;
                else addr_next = {addr_reg[7:0], hex[3:0]};
            end
            else if (column_reg == COL_COLON)
            begin
                if (char_code != CH_COLON) hbad_next = 1'b1;
            end
            else if (column_reg == COL_SPACE)
            begin
                six_next = (char_code == CH_SPACE);
            end
            else if (column_reg >= COL_DATA && column_reg < COL_PIPE)
            begin
                // data run: hex digits, then blanks only
                if (ended_reg)
                begin
                    if (char_code != CH_SPACE) dbad_next = 1'b1;
                end
                else if (char_code == CH_SPACE)
                begin
                    ended_next = 1'b1;
                end
                else if (!hex[4])
                begin
                    dbad_next = 1'b1;
                end
                else
                begin
                    digits_next = digits_reg + 5'd1;
                    if (!digits_reg[0])
                    begin
                        hi_next = hex[3:0];
                    end
                    else if (byte_idx < 4'(MAX_LINE_BYTES))
                    begin
                        buf_wr_en = 1'b1;
                    end
                end
            end
            else
            begin
                pipe_next = (char_code == CH_PIPE);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= 5'd0;
            addr_reg   <= 12'd0;
            digits_reg <= 5'd0;
            ended_reg  <= 1'b0;
            blank_reg  <= 1'b1;
            hbad_reg   <= 1'b0;
            dbad_reg   <= 1'b0;
            pipe_reg   <= 1'b0;
            six_reg    <= 1'b0;
        end
        else
        begin
            column_reg <= column_next;
            addr_reg   <= addr_next;
            digits_reg <= digits_next;
            ended_reg  <= ended_next;
            blank_reg  <= blank_next;
            hbad_reg   <= hbad_next;
            dbad_reg   <= dbad_next;
            pipe_reg   <= pipe_next;
            six_reg    <= six_next;
        end
    end

    // pending high nibble of the byte being assembled
    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
    end

    // summary of the line so far
    always_comb
    begin
        stat.full_len     = (column_reg == LINE_COLS);
        stat.pipe_ok      = pipe_reg;
        stat.all_blank    = blank_reg;
        stat.header_bad   = hbad_reg;
        stat.data_bad     = dbad_reg;
        stat.digit_odd    = digits_reg[0];
        stat.space_six_ok = six_reg;
        stat.bytes        = digits_reg[4:1];
        stat.address      = addr_reg;
    end

endmodule

`default_nettype wire

>>> rtl/hex_object_line_loader_core.sv
// order: a line end without bytes has its status in the output register in the cycle
// after it is taken, a line with bytes has its first write there after S_RD and S_WR
// throughput: one character per cycle while the core is in S_RUN and its output
// register is free; an accepted line holds the input while each byte is read from the
// byte buffer memory in S_RD and sent in S_WR, and then while S_STAT sends the status
// reset: asynchronous, clears line state, write history and halt; buffer is not cleared
`default_nettype none

module hex_object_line_loader_core #(
    parameter int MEM_BYTES      = 4096,
    parameter int MAX_LINE_BYTES = 10
) (
    input  wire logic clk,
    input  wire logic rst_n,
    hol_in_if.sink    in_ch,
    hol_out_if.source out_ch
);

    import hol_pkg::*;

    localparam int BufAw = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;

    typedef enum logic [3:0] {
        S_RUN  = 4'b0001,
        S_RD   = 4'b0010,
        S_WR   = 4'b0100,
        S_STAT = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic        halted_reg, halted_next;
    logic        any_wr_reg, any_wr_next;
    logic [11:0] last_wr_reg, last_wr_next;
    logic [11:0] base_reg, base_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [3:0]  idx_reg, idx_next;
    logic        ovalid_reg, ovalid_next;
    logic [1:0]  okind_reg, okind_next;
    logic [11:0] oaddr_reg, oaddr_next;
    logic [7:0]  odata_reg, odata_next;
    logic        olast_reg, olast_next;

    line_stat_t       stat;
    logic             buf_wr_en;
    logic [BufAw-1:0] buf_wr_addr;
    logic [7:0]       buf_wr_data;
    logic [7:0]       buf_rd_data;
    logic             out_free;
    logic             in_fire;
    logic             char_take;
    logic             line_clear;
    logic             line_good;
    logic [12:0]      end_addr;

    assign out_free   = !ovalid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == S_RUN) && out_free;
    assign in_fire    = in_ch.valid && in_ch.ready;
    assign char_take  = in_fire && !in_ch.line_end && !halted_reg;
    assign line_clear = in_fire && in_ch.line_end;

    hol_parse #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_take   (char_take),
        .char_code   (in_ch.char_code),
        .line_clear  (line_clear),
        .stat        (stat),
        .buf_wr_en   (buf_wr_en),
        .buf_wr_addr (buf_wr_addr),
        .buf_wr_data (buf_wr_data)
    );

    hol_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LINE_BYTES)
    ) u_buf (
        .clk     (clk),
        .wr_en   (buf_wr_en),
        .wr_addr (buf_wr_addr),
        .wr_data (buf_wr_data),
        .rd_addr (idx_reg[BufAw-1:0]),
        .rd_data (buf_rd_data)
    );

    // line acceptance at line end
    assign end_addr = {1'b0, stat.address} + {9'd0, stat.bytes};
    always_comb
    begin
        line_good = stat.full_len && stat.pipe_ok;
        if (!stat.all_blank)
        begin
            if (stat.header_bad || stat.data_bad || stat.digit_odd)
                line_good = 1'b0;
            if (stat.bytes != 4'd0 && !stat.space_six_ok)
                line_good = 1'b0;
            if (stat.bytes > 4'(MAX_LINE_BYTES))
                line_good = 1'b0;
            if (any_wr_reg && stat.address <= last_wr_reg)
                line_good = 1'b0;
            if (end_addr > 13'(MEM_BYTES))
                line_good = 1'b0;
        end
    end

    // sequencer: line end decision, then buffer readout and status
    always_comb
    begin
        state_next   = state_reg;
        halted_next  = halted_reg;
        any_wr_next  = any_wr_reg;
        last_wr_next = last_wr_reg;
        base_next    = base_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        ovalid_next  = ovalid_reg && !out_ch.ready;
        okind_next   = okind_reg;
        oaddr_next   = oaddr_reg;
        odata_next   = odata_reg;
        olast_next   = olast_reg;
        case (state_reg)
            S_RUN:
            begin
                if (line_clear)
                begin
                    ovalid_next = 1'b1;
                    oaddr_next  = 12'd0;
                    odata_next  = 8'd0;
                    olast_next  = 1'b1;
                    if (halted_reg)
                    begin
                        okind_next = KIND_IGNORED;
                    end
                    else if (!line_good)
                    begin
                        okind_next  = KIND_REJECT;
                        halted_next = 1'b1;
                    end
                    else if (stat.all_blank || stat.bytes == 4'd0)
                    begin
                        okind_next = KIND_ACCEPT;
                    end
                    else
                    begin
                        // the write results come before the status
                        ovalid_next  = 1'b0;
                        base_next    = stat.address;
                        cnt_next     = stat.bytes;
                        idx_next     = 4'd0;
                        any_wr_next  = 1'b1;
                        last_wr_next = 12'(end_addr - 13'd1);
                        state_next   = S_RD;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = KIND_WRITE;
                    oaddr_next  = base_reg + {8'd0, idx_reg};
                    odata_next  = buf_rd_data;
                    olast_next  = 1'b0;
                    idx_next    = idx_reg + 4'd1;
                    state_next  = (idx_reg + 4'd1 == cnt_reg) ? S_STAT : S_RD;
                end
            end
            S_STAT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = KIND_ACCEPT;
                    oaddr_next  = 12'd0;
                    odata_next  = 8'd0;
                    olast_next  = 1'b1;
                    state_next  = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_RUN;
            halted_reg  <= 1'b0;
            any_wr_reg  <= 1'b0;
            last_wr_reg <= 12'd0;
            ovalid_reg  <= 1'b0;
            cnt_reg     <= 4'd0;
            idx_reg     <= 4'd0;
        end
        else
        begin
            state_reg   <= state_next;
            halted_reg  <= halted_next;
            any_wr_reg  <= any_wr_next;
            last_wr_reg <= last_wr_next;
            ovalid_reg  <= ovalid_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        okind_reg <= okind_next;
        oaddr_reg <= oaddr_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
    end

    assign out_ch.valid         = ovalid_reg;
    assign out_ch.result_kind   = okind_reg;
    assign out_ch.write_address = oaddr_reg;
    assign out_ch.write_data    = odata_reg;
    assign out_ch.last_of_run   = olast_reg;

    // checks
    a_no_write_when_halted: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.result_kind == KIND_WRITE |-> !halted_reg)
        else $error("memory write while halted");

    a_halt_reports_reject: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(halted_reg) |-> out_ch.valid && out_ch.result_kind == KIND_REJECT)
        else $error("halt without reject transaction");

    a_halted_line_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_ch.line_end && halted_reg |=>
        out_ch.valid && out_ch.result_kind == KIND_IGNORED && out_ch.last_of_run)
        else $error("line end after halt not reported as ignored");

    a_readout_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD || state_reg == S_WR |-> idx_reg < cnt_reg)
        else $error("buffer readout index out of range");

endmodule

`default_nettype wire
